[hdl/cdtc_pkg.sv]
// Types and constants shared by the clock divider timing calculator.
package cdtc_pkg;

    localparam int LANES   = 2;
    localparam int NQ_W    = 64;
    localparam int DEN_W   = 40;
    localparam int REM_W   = DEN_W + 1;
    localparam int N_CELLS = NQ_W;

    localparam logic [15:0] SETUP_NS_RST  = 16'd10;
    localparam logic [7:0]  BUSY_CYC_RST  = 8'd64;
    localparam logic [29:0] NS_PER_S      = 30'd1000000000;
    localparam logic [29:0] NS_PER_S_M1   = 30'd999999999;
    localparam logic [39:0] DIV_ONE       = 40'd256;
    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;

    typedef enum logic {
        CFG_SETUP_NS = 1'b0,
        CFG_BUSY_CYC = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] system_hz;
        logic [31:0] target_hz;
        logic        round_up_mode;
    } t_in;

    typedef struct packed {
        logic [31:0] divider_integer;
        logic [7:0]  divider_fraction;
        logic [30:0] actual_hz;
        logic [31:0] setup_sys_cycles;
        logic [31:0] busy_sys_cycles;
        logic [31:0] busy_wait_ns;
        logic        calc_error;
    } t_out;

    // one division lane: partial remainder, dividend/quotient shift word, divisor
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NQ_W-1:0]  nq;
        logic [DEN_W-1:0] den;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lanes;

    // values carried alongside the divisions
    typedef struct packed {
        logic [31:0] sys;
        logic        up;
        logic        err;
        logic [39:0] div256;
        logic [30:0] actual;
        logic [31:0] setup;
    } t_side;

endpackage

[hdl/cdtc_cell.sv]
// One restoring division step per lane, registered.
module cdtc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cdtc_pkg::t_lanes i_lanes,
    input  cdtc_pkg::t_side  i_side,
    output logic            o_valid,
    output cdtc_pkg::t_lanes o_lanes,
    output cdtc_pkg::t_side  o_side
);
    import cdtc_pkg::*;

    logic   r_valid;
    t_lanes r_lanes, n_lanes;
    t_side  r_side;

    always_comb begin
        logic [REM_W-1:0] t;
        logic             ge;
        for (int l = 0; l < LANES; l++) begin
            t  = {i_lanes[l].rem[REM_W-2:0], i_lanes[l].nq[NQ_W-1]};
            ge = (t >= {1'b0, i_lanes[l].den});
            n_lanes[l].rem = ge ? (t - {1'b0, i_lanes[l].den}) : t;
            n_lanes[l].nq  = {i_lanes[l].nq[NQ_W-2:0], ge};
            n_lanes[l].den = i_lanes[l].den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;
    assign o_side  = r_side;
endmodule

[hdl/cdtc_chain.sv]
// Row of division cells: one quotient bit per cell, one item per cycle while i_en is high.
module cdtc_chain (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  logic [cdtc_pkg::LANES-1:0][cdtc_pkg::NQ_W-1:0]  i_num,
    input  logic [cdtc_pkg::LANES-1:0][cdtc_pkg::DEN_W-1:0] i_den,
    input  cdtc_pkg::t_side                              i_side,
    output logic                                         o_valid,
    output logic [cdtc_pkg::LANES-1:0][cdtc_pkg::NQ_W-1:0]  o_quo,
    output cdtc_pkg::t_side                              o_side
);
    import cdtc_pkg::*;

    logic   valid [N_CELLS+1];
    t_lanes lanes [N_CELLS+1];
    t_side  side  [N_CELLS+1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lanes[0][l].rem = '0;
            lanes[0][l].nq  = i_num[l];
            lanes[0][l].den = i_den[l];
        end
    end
    assign valid[0] = i_valid;
    assign side[0]  = i_side;

    for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
        cdtc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (valid[c]),
            .i_lanes (lanes[c]),
            .i_side  (side[c]),
            .o_valid (valid[c+1]),
            .o_lanes (lanes[c+1]),
            .o_side  (side[c+1])
        );
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = lanes[N_CELLS][l].nq;
        end
    end
    assign o_valid = valid[N_CELLS];
    assign o_side  = side[N_CELLS];
endmodule

[hdl/clock_divider_timing_calc_top.sv]
// Top level of the clock divider timing calculator.
//
// Input channel: i_valid / i_data / o_stall. Output channel: o_valid /
// o_data / i_stall. A transfer happens on a rising edge with valid high and
// stall low. Each request gives exactly one result, in order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 setup time in ns, 1 busy duration in output clocks); write only when idle.
// The pipeline is one capture stage, a 64-cell divider row for the divider and
// setup time, one stage, a 64-cell row for the actual frequency, one stage,
// a 64-cell row for both busy waits, and one output register.
// Throughput is one request per cycle while o_stall is low; each cell row
// resolves one quotient bit per cell.
// While a result waits under i_stall the next one parks in a skid register;
// the pipeline holds only once that is full, and o_stall is its flag, so
// o_stall is registered. Synchronous reset empties the pipeline and sets
// the registers to 10 ns and 64 output clocks.
module clock_divider_timing_calc_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cdtc_pkg::t_in   i_data,
    output logic            o_stall,
    output logic            o_valid,
    output cdtc_pkg::t_out  o_data,
    input  logic            i_stall,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);
    import cdtc_pkg::*;

    logic        adv;
    logic        out_take;
    logic [15:0] r_setup_ns;
    logic [7:0]  r_busy_cyc;
    logic        r_skid_valid;
    t_out        r_skid;

    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_ns <= SETUP_NS_RST;
            r_busy_cyc <= BUSY_CYC_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SETUP_NS: r_setup_ns <= i_cfg_data;
                CFG_BUSY_CYC: r_busy_cyc <= i_cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // capture stage: numerators and divisors for the first row
    logic                              r0_valid;
    logic [LANES-1:0][NQ_W-1:0]        r0_num, n0_num;
    logic [LANES-1:0][DEN_W-1:0]       r0_den, n0_den;
    t_side                             r0_side, n0_side;

    always_comb begin
        n0_side        = '0;
        n0_side.sys    = i_data.system_hz;
        n0_side.up     = i_data.round_up_mode;
        n0_side.err    = (i_data.target_hz == '0);
        if (i_data.round_up_mode) begin
            n0_num[0] = {32'd0, i_data.system_hz} + {31'd0, i_data.target_hz, 1'b0} - 64'd1;
            n0_den[0] = {7'd0, i_data.target_hz, 1'b0};
        end else begin
            n0_num[0] = {25'd0, i_data.system_hz, 7'd0} + {33'd0, i_data.target_hz[31:1]};
            n0_den[0] = {8'd0, i_data.target_hz};
        end
        n0_num[1] = {16'd0, 48'(i_data.system_hz) * 48'(r_setup_ns)} + {34'd0, NS_PER_S_M1};
        n0_den[1] = {10'd0, NS_PER_S};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (adv) begin
            r0_valid <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_num  <= n0_num;
            r0_den  <= n0_den;
            r0_side <= n0_side;
        end
    end

    logic                       c1_valid;
    logic [LANES-1:0][NQ_W-1:0] c1_quo;
    t_side                      c1_side;

    cdtc_chain u_chain_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_valid (r0_valid), .i_num (r0_num), .i_den (r0_den), .i_side (r0_side),
        .o_valid (c1_valid), .o_quo (c1_quo), .o_side (c1_side)
    );

    // divider in 1/256 steps, clamped to one
    logic                        r1_valid;
    logic [LANES-1:0][NQ_W-1:0]  r1_num, n1_num;
    logic [LANES-1:0][DEN_W-1:0] r1_den, n1_den;
    t_side                       r1_side, n1_side;
    logic [39:0]                 div_raw;

    always_comb begin
        div_raw = c1_side.up ? {c1_quo[0][31:0], 8'h00} : c1_quo[0][39:0];
        n1_side        = c1_side;
        n1_side.div256 = (div_raw < DIV_ONE) ? DIV_ONE : div_raw;
        n1_side.setup  = c1_quo[1][31:0];
        n1_num[0] = {25'd0, c1_side.sys, 7'd0};
        n1_den[0] = n1_side.div256;
        n1_num[1] = '0;
        n1_den[1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= c1_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_num  <= n1_num;
            r1_den  <= n1_den;
            r1_side <= n1_side;
        end
    end

    logic                       c2_valid;
    logic [LANES-1:0][NQ_W-1:0] c2_quo;
    t_side                      c2_side;

    cdtc_chain u_chain_act (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_valid (r1_valid), .i_num (r1_num), .i_den (r1_den), .i_side (r1_side),
        .o_valid (c2_valid), .o_quo (c2_quo), .o_side (c2_side)
    );

    // busy waits from the actual frequency, both rounded up
    logic                        r2_valid;
    logic [LANES-1:0][NQ_W-1:0]  r2_num, n2_num;
    logic [LANES-1:0][DEN_W-1:0] r2_den, n2_den;
    t_side                       r2_side, n2_side;
    logic [30:0]                 act;

    always_comb begin
        act            = c2_quo[0][30:0];
        n2_side        = c2_side;
        n2_side.actual = act;
        n2_side.err    = c2_side.err || (act == '0);
        n2_num[0] = {24'd0, 40'(c2_side.sys) * 40'(r_busy_cyc)} + {33'd0, act} - 64'd1;
        n2_num[1] = {26'd0, 38'(r_busy_cyc) * 38'(NS_PER_S)} + {33'd0, act} - 64'd1;
        n2_den[0] = {9'd0, act};
        n2_den[1] = {9'd0, act};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= c2_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_num  <= n2_num;
            r2_den  <= n2_den;
            r2_side <= n2_side;
        end
    end

    logic                       c3_valid;
    logic [LANES-1:0][NQ_W-1:0] c3_quo;
    t_side                      c3_side;

    cdtc_chain u_chain_busy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_valid (r2_valid), .i_num (r2_num), .i_den (r2_den), .i_side (r2_side),
        .o_valid (c3_valid), .o_quo (c3_quo), .o_side (c3_side)
    );

    logic r_out_valid;
    t_out r_out, n_out;

    always_comb begin
        n_out = '0;
        if (c3_side.err) begin
            n_out.calc_error = 1'b1;
        end else begin
            n_out.divider_integer  = c3_side.div256[39:8];
            n_out.divider_fraction = c3_side.div256[7:0];
            n_out.actual_hz        = c3_side.actual;
            n_out.setup_sys_cycles = c3_side.setup;
            n_out.busy_sys_cycles  = (c3_quo[0][NQ_W-1:32] != '0) ? SAT32 : c3_quo[0][31:0];
            n_out.busy_wait_ns     = (c3_quo[1][NQ_W-1:32] != '0) ? SAT32 : c3_quo[1][31:0];
        end
    end

    // output register may take a new value when empty or when its transfer happens
    assign out_take = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (out_take) begin
            r_out_valid <= c3_valid;
        end else if (c3_valid) begin
            r_skid_valid <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (out_take) begin
            r_out <= n_out;
        end else begin
            r_skid <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a held result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.calc_error) |->
            (o_data.actual_hz == '0 && o_data.divider_integer == '0 &&
             o_data.busy_wait_ns == '0))
        else $error("error result carries non-zero fields");

    a_ok_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.calc_error) |->
            (o_data.actual_hz != '0 && o_data.divider_integer != '0))
        else $error("good result with zero frequency or divider");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("held result changed");
endmodule
